@@ design/cwmc_pkg.sv @@
// ============================================================================
// cwmc_pkg
// Shared types, field widths and register codes of the workload mode classifier.
// ============================================================================
package cwmc_pkg;

    localparam int UTIL_W     = 11;
    localparam int IPC_W      = 11;
    localparam int RATE_W     = 24;
    localparam int VAR_W      = 20;
    localparam int CONF_W     = 8;
    localparam int UTIL_SQ_W  = 2 * UTIL_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_DATA_W   = 48;   // 46 bits of fields, padded to bytes
    localparam int M_DATA_W   = 8;

    localparam int WINDOW_LEN_DEF = 8;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [1:0] {
        MODE_IDLE        = 2'd0,
        MODE_INTERACTIVE = 2'd1,
        MODE_COMPUTE     = 2'd2,
        MODE_LC          = 2'd3
    } mode_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_CEILING      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAT_UTIL_FLOOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAT_RATE_FLOOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAT_VAR_FLOOR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMP_UTIL_FLOOR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COMP_IPC_FLOOR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COMP_RATE_CEILING = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT     = 3'd7;

    // reset values
    localparam logic [UTIL_W-1:0] RST_IDLE_CEILING      = 11'd240;
    localparam logic [UTIL_W-1:0] RST_LAT_UTIL_FLOOR    = 11'd960;
    localparam logic [RATE_W-1:0] RST_LAT_RATE_FLOOR    = 24'd15000;
    localparam logic [VAR_W-1:0]  RST_LAT_VAR_FLOOR     = 20'd38400;
    localparam logic [UTIL_W-1:0] RST_COMP_UTIL_FLOOR   = 11'd1280;
    localparam logic [IPC_W-1:0]  RST_COMP_IPC_FLOOR    = 11'd256;
    localparam logic [RATE_W-1:0] RST_COMP_RATE_CEILING = 24'd8000;
    localparam logic [CONF_W-1:0] RST_CONFIRM_COUNT     = 8'd3;

    typedef struct packed {
        logic [UTIL_W-1:0] idle_ceiling;
        logic [UTIL_W-1:0] lat_util_floor;
        logic [RATE_W-1:0] lat_rate_floor;
        logic [VAR_W-1:0]  lat_var_floor;
        logic [UTIL_W-1:0] comp_util_floor;
        logic [IPC_W-1:0]  comp_ipc_floor;
        logic [RATE_W-1:0] comp_rate_ceiling;
        logic [CONF_W-1:0] confirm_count;
    } cfg_t;

    // pre-classified sample handed from front to back
    typedef struct packed {
        logic                 is_idle;
        logic                 lc_base;
        logic                 compute_ok;
        logic [UTIL_W-1:0]    util;
        logic [UTIL_SQ_W-1:0] util_sq;
    } front_item_t;

    typedef struct packed {
        logic busy;
        logic full;
    } back_stat_t;

endpackage

@@ design/cwmc_ram.sv @@
// ============================================================================
// cwmc_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module cwmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/cwmc_front.sv @@
// ============================================================================
// cwmc_front
// Input side: takes samples and evaluates the threshold tests.
// ============================================================================
module cwmc_front
    import cwmc_pkg::*;
(
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [UTIL_W-1:0] util_sample,
    input  logic [IPC_W-1:0]  ipc_sample,
    input  logic [RATE_W-1:0] switch_rate,
    input  cfg_t              cfg,
    input  logic              q_full,
    output logic              q_push,
    output front_item_t       q_item
);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb
    begin
        q_item.is_idle    = util_sample < cfg.idle_ceiling;
        // the variance part of the latency-critical test is done in the back end
        q_item.lc_base    = (util_sample >= cfg.lat_util_floor) &&
                            (switch_rate >= cfg.lat_rate_floor);
        q_item.compute_ok = (util_sample >= cfg.comp_util_floor) &&
                            (ipc_sample >= cfg.comp_ipc_floor) &&
                            (switch_rate <= cfg.comp_rate_ceiling);
        q_item.util       = util_sample;
        q_item.util_sq    = UTIL_SQ_W'(util_sample) * UTIL_SQ_W'(util_sample);
    end

endmodule

@@ design/cwmc_queue.sv @@
// ============================================================================
// cwmc_queue
// Short FIFO between the front and back ends.
// ============================================================================
module cwmc_queue
    import cwmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  front_item_t push_item,
    output logic        full,
    input  logic        pop,
    output logic        valid,
    output front_item_t pop_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    front_item_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full     = count_reg == CNT_W'(QUEUE_DEPTH);
    assign valid    = count_reg != '0;
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ design/cwmc_back.sv @@
// ============================================================================
// cwmc_back
// Back end: utilization window, variance test, mode commit and result register.
// ============================================================================
module cwmc_back
    import cwmc_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  front_item_t       q_item,
    output logic              q_pop,
    input  logic [VAR_W-1:0]  var_min,
    input  logic [CONF_W-1:0] confirm,
    output logic              out_valid,
    input  logic              out_ready,
    output mode_t             out_committed,
    output mode_t             out_raw,
    output back_stat_t        stat
);

    localparam int POS_W  = $clog2(WINDOW_LEN);
    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W  = UTIL_W + $clog2(WINDOW_LEN);
    localparam int SQ_W   = UTIL_SQ_W + $clog2(WINDOW_LEN);
    localparam int P1_W   = SQ_W + FILL_W;
    localparam int P2_W   = 2 * SUM_W;
    localparam int NN_W   = 2 * FILL_W;
    localparam int P3_W   = VAR_W + NN_W;
    localparam int CMP_A  = (P1_W > P2_W) ? P1_W : P2_W;
    localparam int CMP_W  = (CMP_A > P3_W) ? CMP_A : P3_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MULT,
        ST_DECIDE
    } state_t;

    state_t             state_reg,     state_next;
    front_item_t        item_reg,      item_next;
    logic [FILL_W-1:0]  fill_reg,      fill_next;
    logic [POS_W-1:0]   pos_reg,       pos_next;
    logic [SUM_W-1:0]   sum_reg,       sum_next;
    logic [SQ_W-1:0]    sumsq_reg,     sumsq_next;
    logic [NN_W-1:0]    nn_reg,        nn_next;
    logic [P1_W-1:0]    p1_reg,        p1_next;
    logic [P2_W-1:0]    p2_reg,        p2_next;
    logic [P3_W-1:0]    p3_reg,        p3_next;
    mode_t              cand_reg,      cand_next;
    logic [CONF_W-1:0]  cnt_reg,       cnt_next;
    mode_t              cur_reg,       cur_next;
    logic               out_valid_reg, out_valid_next;
    mode_t              out_raw_reg,   out_raw_next;

    logic [UTIL_W-1:0]    ram_rdata;
    logic                 ram_we;
    logic                 ram_re;
    logic [UTIL_SQ_W-1:0] old_sq;
    logic                 win_full;
    logic                 var_ok;
    mode_t                raw;

    cwmc_ram #(
        .WIDTH (UTIL_W),
        .DEPTH (WINDOW_LEN)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (item_reg.util),
        .re    (ram_re),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    assign win_full = fill_reg == FILL_W'(WINDOW_LEN);
    assign old_sq   = UTIL_SQ_W'(ram_rdata) * UTIL_SQ_W'(ram_rdata);
    assign ram_re   = (state_reg == ST_IDLE) && q_valid;
    assign ram_we   = state_reg == ST_UPDATE;
    assign q_pop    = ram_re;

    // n*sumsq >= sum^2 always holds, so the difference never wraps
    always_comb
    begin
        if (fill_reg < FILL_W'(2))
        begin
            var_ok = var_min == '0;
        end
        else
        begin
            var_ok = (CMP_W'(p1_reg) - CMP_W'(p2_reg)) >= CMP_W'(p3_reg);
        end

        if (item_reg.is_idle)
        begin
            raw = MODE_IDLE;
        end
        else if (item_reg.lc_base && var_ok)
        begin
            raw = MODE_LC;
        end
        else if (item_reg.compute_ok)
        begin
            raw = MODE_COMPUTE;
        end
        else
        begin
            raw = MODE_INTERACTIVE;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        fill_next      = fill_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        sumsq_next     = sumsq_reg;
        nn_next        = nn_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        p3_next        = p3_reg;
        cand_next      = cand_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_raw_next   = out_raw_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    item_next  = q_item;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                // oldest entry leaves the sums once the window is full
                if (win_full)
                begin
                    sum_next   = sum_reg - SUM_W'(ram_rdata) + SUM_W'(item_reg.util);
                    sumsq_next = sumsq_reg - SQ_W'(old_sq) + SQ_W'(item_reg.util_sq);
                end
                else
                begin
                    fill_next  = fill_reg + 1'b1;
                    sum_next   = sum_reg + SUM_W'(item_reg.util);
                    sumsq_next = sumsq_reg + SQ_W'(item_reg.util_sq);
                end
                nn_next    = NN_W'(fill_next) * NN_W'(fill_next);
                pos_next   = (pos_reg == POS_W'(WINDOW_LEN - 1)) ? '0 : pos_reg + 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                p1_next    = P1_W'(fill_reg) * P1_W'(sumsq_reg);
                p2_next    = P2_W'(sum_reg) * P2_W'(sum_reg);
                p3_next    = P3_W'(var_min) * P3_W'(nn_reg);
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    if (raw == cand_reg)
                    begin
                        cnt_next = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;
                    end
                    else
                    begin
                        cand_next = raw;
                        cnt_next  = CONF_W'(1);
                    end
                    if (cnt_next >= confirm)
                    begin
                        cur_next = raw;
                    end
                    out_valid_next = 1'b1;
                    out_raw_next   = raw;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            item_reg      <= '0;
            fill_reg      <= '0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            sumsq_reg     <= '0;
            nn_reg        <= '0;
            p1_reg        <= '0;
            p2_reg        <= '0;
            p3_reg        <= '0;
            cand_reg      <= MODE_IDLE;
            cnt_reg       <= '0;
            cur_reg       <= MODE_IDLE;
            out_valid_reg <= 1'b0;
            out_raw_reg   <= MODE_IDLE;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            sumsq_reg     <= sumsq_next;
            nn_reg        <= nn_next;
            p1_reg        <= p1_next;
            p2_reg        <= p2_next;
            p3_reg        <= p3_next;
            cand_reg      <= cand_next;
            cnt_reg       <= cnt_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
            out_raw_reg   <= out_raw_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_committed = cur_reg;
    assign out_raw       = out_raw_reg;
    assign stat.busy     = state_reg != ST_IDLE;
    assign stat.full     = win_full;

endmodule

@@ design/cpu_workload_mode_classifier.sv @@
// ============================================================================
// cpu_workload_mode_classifier
// Classifies periodic CPU samples into idle, interactive, compute or
// latency-critical modes and commits a mode once it repeats.
// ============================================================================
// Each sample transaction yields one result transaction: the committed mode in
// m_tdata[1:0] and the raw mode of this sample in m_tdata[3:2]. The front end
// evaluates the threshold tests as the sample is accepted and parks it in a
// two-entry queue; the back end then takes it through these steps in order (queue pop and
// window read, window and sums update, the three variance products, decision),
// and pops no new sample until its decision is made; that step waits while a
// result is still held on m_tready. The variance is tested as n*sumsq - sum^2
// >= lat_var_floor*n^2 over the last WINDOW_LEN utilization values. Samples are
// accepted while the queue has room, also while a result waits on m_tready.
// Configuration writes are always ready and take effect on the next sample;
// write them only while no sample is in flight.
module cpu_workload_mode_classifier
    import cwmc_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // util_sample[10:0], ipc_sample[21:11], switch_rate[45:22], zero pad
    input  logic [S_DATA_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // commit_mode[1:0], raw_mode[3:2], zero pad
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic        q_full;
    logic        q_push;
    logic        q_pop;
    logic        q_valid;
    front_item_t push_item;
    front_item_t pop_item;
    mode_t       committed;
    mode_t       raw;
    back_stat_t  stat;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IDLE_CEILING:      cfg_next.idle_ceiling      = cfg_data[UTIL_W-1:0];
                CFG_LAT_UTIL_FLOOR:    cfg_next.lat_util_floor    = cfg_data[UTIL_W-1:0];
                CFG_LAT_RATE_FLOOR:    cfg_next.lat_rate_floor    = cfg_data[RATE_W-1:0];
                CFG_LAT_VAR_FLOOR:     cfg_next.lat_var_floor     = cfg_data[VAR_W-1:0];
                CFG_COMP_UTIL_FLOOR:   cfg_next.comp_util_floor   = cfg_data[UTIL_W-1:0];
                CFG_COMP_IPC_FLOOR:    cfg_next.comp_ipc_floor    = cfg_data[IPC_W-1:0];
                CFG_COMP_RATE_CEILING: cfg_next.comp_rate_ceiling = cfg_data[RATE_W-1:0];
                CFG_CONFIRM_COUNT:     cfg_next.confirm_count     = cfg_data[CONF_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_ceiling      <= RST_IDLE_CEILING;
            cfg_reg.lat_util_floor    <= RST_LAT_UTIL_FLOOR;
            cfg_reg.lat_rate_floor    <= RST_LAT_RATE_FLOOR;
            cfg_reg.lat_var_floor     <= RST_LAT_VAR_FLOOR;
            cfg_reg.comp_util_floor   <= RST_COMP_UTIL_FLOOR;
            cfg_reg.comp_ipc_floor    <= RST_COMP_IPC_FLOOR;
            cfg_reg.comp_rate_ceiling <= RST_COMP_RATE_CEILING;
            cfg_reg.confirm_count     <= RST_CONFIRM_COUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cwmc_front u_front (
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .util_sample (s_tdata[UTIL_W-1:0]),
        .ipc_sample  (s_tdata[UTIL_W+IPC_W-1:UTIL_W]),
        .switch_rate (s_tdata[UTIL_W+IPC_W+RATE_W-1:UTIL_W+IPC_W]),
        .cfg         (cfg_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    cwmc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (pop_item)
    );

    cwmc_back #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (pop_item),
        .q_pop         (q_pop),
        .var_min       (cfg_reg.lat_var_floor),
        .confirm       (cfg_reg.confirm_count),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_committed (committed),
        .out_raw       (raw),
        .stat          (stat)
    );

    assign m_tdata = {4'b0000, raw, committed};

    // once full, the window stays full
    assert property (@(posedge clk) disable iff (!rst_n) stat.full |=> stat.full)
        else $error("window fill dropped after reaching full");

    // no new sample leaves the queue while the back end is busy
    assert property (@(posedge clk) disable iff (!rst_n) stat.busy |-> !q_pop)
        else $error("queue popped while back end busy");

    // a fresh result follows a queue pop by exactly the back-end sequence
    assert property (@(posedge clk) disable iff (!rst_n) $rose(m_tvalid) |-> $past(q_pop, 4))
        else $error("result appeared without matching sample");

endmodule
